@@ rtl/dcfd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfd_pkg - dashboard command frame decoder shared definitions
// Frame layout constants, character codes and the packed update type.
// ----------------------------------------------------------------------------
package dcfd_pkg;

    // Frame characters
    localparam logic [7:0] START_CHAR = 8'h24;   // '$'
    localparam logic [7:0] END_CHAR   = 8'h7C;   // '|'
    localparam logic [7:0] DIGIT_BASE = 8'h30;   // '0'

    // Frame geometry: 16 characters, '$' at position 0, '|' at position 15
    localparam int FRAME_LEN  = 16;
    localparam int POS_W      = $clog2(FRAME_LEN);
    localparam int COUNT_W    = 8;               // counter wraps from 255 to 0

    // Character positions inside a frame
    localparam int RPM_POS_0   = 1;
    localparam int SPEED_POS_0 = 6;
    localparam int LEFT_POS    = 10;
    localparam int RIGHT_POS   = 12;
    localparam int BEAM_POS    = 14;

    // Lamp command values
    localparam logic [7:0] LAMP_CMD_ON  = 8'd1;
    localparam logic [7:0] LAMP_CMD_OFF = 8'd2;

    // Lamp bit positions in the latched lamp vector
    localparam int LAMP_LEFT  = 0;
    localparam int LAMP_RIGHT = 1;
    localparam int LAMP_BEAM  = 2;
    localparam int LAMP_N     = 3;

    localparam int TDATA_W = 32;

    typedef logic [7:0] byte_t;
    typedef logic [FRAME_LEN-1:0][7:0] frame_t;
    typedef logic [LAMP_N-1:0] lamps_t;

    // One update, engine speed in the lowest bits
    typedef struct packed {
        logic        beam_lamp_on;
        logic        right_lamp_on;
        logic        left_lamp_on;
        logic        speed_changed;
        logic [7:0]  road_speed;
        logic [15:0] engine_rpm;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

@@ rtl/dash_command_frame_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dash_command_frame_decoder - dashboard command frame decoder
// Collects "$rrrr sss l r h|" frames from a byte stream and issues one
// update item per complete 16-character frame.
// ----------------------------------------------------------------------------
//  Channel | Dir | Ports                     | tdata fields (lowest bit up)
//  --------+-----+---------------------------+-------------------------------
//  s_      | in  | s_tvalid s_tready s_tdata | rx_byte[7:0]
//  m_      | out | m_tvalid m_tready m_tdata | engine_rpm[15:0] road_speed[7:0]
//          |     |                           | speed_changed left_lamp_on
//          |     |                           | right_lamp_on beam_lamp_on, pad
//
//  One item per cycle while m_tready does not stall the output: input
//  register, then frame update and decode into the output register;
//  m_tvalid rises when the closing '|' reaches the output register.
//  Reset (aresetn low, synchronous) clears the position counter, last speed,
//  lamp states and both valid flags; no clearing pass is needed.
//  A stall on m_tready holds the output item and the one item in the input
//  register; s_tready drops only while both are held.
// ----------------------------------------------------------------------------
module dash_command_frame_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [15:0] engine_rpm, [23:16] road_speed,
                                   // [24] speed_changed, [25] left_lamp_on,
                                   // [26] right_lamp_on, [27] beam_lamp_on,
                                   // [31:28] zero
);
    import dcfd_pkg::*;

    // Input register
    logic   in_valid_reg;
    byte_t  in_byte_reg;

    // Frame state
    logic [COUNT_W-1:0] count_reg, count_next;
    frame_t             frame_reg;
    byte_t              last_speed_reg;
    lamps_t             lamps_reg;

    // Output register
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;

    // Process step
    logic               advance;
    logic               keep;
    logic               store;
    logic               emit;
    logic [COUNT_W-1:0] pos;
    lamps_t             lamps_dec;
    result_t            result_dec;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Position of the current byte and whether it is kept
    always_comb begin
        keep = 1'b1;
        pos  = count_reg;
        if (in_byte_reg == START_CHAR) begin
            pos = '0;
        end else if (count_reg == '0) begin
            keep = 1'b0;
        end
        count_next = pos + COUNT_W'(1);
        store = advance && keep && (pos < COUNT_W'(FRAME_LEN));
        emit  = advance && keep && (in_byte_reg == END_CHAR)
             && (count_next == COUNT_W'(FRAME_LEN));
    end

    dcfd_decode u_decode (
        .frame      (frame_reg),
        .last_speed (last_speed_reg),
        .lamps_in   (lamps_reg),
        .lamps_out  (lamps_dec),
        .result     (result_dec)
    );

    // Output valid: load on an update, clear when taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            count_reg      <= '0;
            last_speed_reg <= '0;
            lamps_reg      <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            out_valid_reg <= out_valid_next;
            if (advance && keep) begin
                count_reg <= count_next;
            end
            if (emit) begin
                last_speed_reg <= result_dec.road_speed;
                lamps_reg      <= lamps_dec;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
        if (store) begin
            frame_reg[pos[POS_W-1:0]] <= in_byte_reg;
        end
        if (emit) begin
            out_reg <= result_dec;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(TDATA_W - RESULT_W)'(0), out_reg};

endmodule

@@ rtl/dcfd_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfd_decode - frame field decode
// Turns the stored frame characters into engine speed, road speed, the
// speed-changed flag and the updated lamp states.
// ----------------------------------------------------------------------------
module dcfd_decode (
    input  dcfd_pkg::frame_t  frame,
    input  dcfd_pkg::byte_t   last_speed,
    input  dcfd_pkg::lamps_t  lamps_in,
    output dcfd_pkg::lamps_t  lamps_out,
    output dcfd_pkg::result_t result
);
    import dcfd_pkg::*;

    // 16-bit digit value, wraps for non-digit characters
    function automatic logic [15:0] digit16(input byte_t ch);
        digit16 = {8'h00, ch} - {8'h00, DIGIT_BASE};
    endfunction

    // One lamp update: on, off or hold
    function automatic logic lamp_apply(input logic cur, input byte_t ch);
        logic [7:0] cmd;
        cmd = ch - DIGIT_BASE;
        if (cmd == LAMP_CMD_ON) begin
            lamp_apply = 1'b1;
        end else if (cmd == LAMP_CMD_OFF) begin
            lamp_apply = 1'b0;
        end else begin
            lamp_apply = cur;
        end
    endfunction

    logic [15:0] rpm;
    logic [7:0]  spd;

    // Engine speed: four digits, weights by constant multiply
    assign rpm = digit16(frame[RPM_POS_0])     * 16'd1000
               + digit16(frame[RPM_POS_0 + 1]) * 16'd100
               + digit16(frame[RPM_POS_0 + 2]) * 16'd10
               + digit16(frame[RPM_POS_0 + 3]);

    // Road speed: three digits, modulo 256
    assign spd = (frame[SPEED_POS_0]     - DIGIT_BASE) * 8'd100
               + (frame[SPEED_POS_0 + 1] - DIGIT_BASE) * 8'd10
               + (frame[SPEED_POS_0 + 2] - DIGIT_BASE);

    // Lamp commands
    assign lamps_out[LAMP_LEFT]  = lamp_apply(lamps_in[LAMP_LEFT],  frame[LEFT_POS]);
    assign lamps_out[LAMP_RIGHT] = lamp_apply(lamps_in[LAMP_RIGHT], frame[RIGHT_POS]);
    assign lamps_out[LAMP_BEAM]  = lamp_apply(lamps_in[LAMP_BEAM],  frame[BEAM_POS]);

    always_comb begin
        result.engine_rpm    = rpm;
        result.road_speed    = spd;
        result.speed_changed = (spd != last_speed);
        result.left_lamp_on  = lamps_out[LAMP_LEFT];
        result.right_lamp_on = lamps_out[LAMP_RIGHT];
        result.beam_lamp_on  = lamps_out[LAMP_BEAM];
    end

endmodule

@@ rtl/dcfd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfd_checker - port checks for the dashboard command frame decoder
// Watches both item channels and the speed-changed flag across updates.
// ----------------------------------------------------------------------------
module dcfd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    import dcfd_pkg::*;

    // Road speed of the last delivered update
    byte_t seen_speed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_speed_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            seen_speed_reg <= m_tdata[23:16];
        end
    end

    // A stalled update holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("update changed while stalled");

    // Reset leaves no update pending and the input open
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("state after reset");

    // A fresh update follows a '|' taken in by the input register
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !$past(m_tvalid)
            |-> $past(s_tvalid && s_tready, 2) && ($past(s_tdata, 2) == END_CHAR))
        else $error("update without closing character");

    // Speed-changed flag matches the previous delivered road speed
    a_changed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[24] == (m_tdata[23:16] != seen_speed_reg)))
        else $error("speed-changed flag mismatch");

endmodule

bind dash_command_frame_decoder dcfd_checker u_dcfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - dashboard command frame decoder
// Drives byte streams of well-formed, broken and noisy "$rrrr sss l r h|"
// frames into the decoder with random idling on both channels. An in-bench
// frame decoder predicts every update item, and the updates taken from the
// decoder are compared field by field in order.
// ----------------------------------------------------------------------------
module testbench;
    import dcfd_pkg::*;

    localparam int    HALF_PERIOD    = 10;
    localparam int    RESET_CYCLES   = 5;
    localparam int    ITEMS_PER_RUN  = 280;    // minimum items sent per random phase
    localparam int    MIN_UPDATES    = 48;
    localparam int    HOLD_CYCLES    = 400;
    localparam int    WATCHDOG_LIMIT = 5000;
    localparam int    SETTLE_CYCLES  = 16;
    localparam int    MAX_REPORTS    = 10;
    localparam byte_t SPACE_CHAR     = 8'h20;

    typedef struct {
        byte_t   rx;
        bit      typed;     // expectation written out in the table
        bit      has_upd;
        result_t upd;
    } stim_row_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;            // [15:0] engine_rpm, [23:16] road_speed,
                                     // [24] speed_changed, [25] left_lamp_on,
                                     // [26] right_lamp_on, [27] beam_lamp_on

    // Predictor state
    logic [COUNT_W-1:0] pos_q;
    byte_t              frame_q [FRAME_LEN];
    byte_t              last_speed_q;
    lamps_t             lamps_q;

    result_t   updates_due_q [$];
    stim_row_t stim_table [$];
    byte_t     speed_prev [3];
    int        tx_idle_pct  = 23;
    int        rx_idle_pct  = 65;
    int        sent_items   = 0;
    int        updates_seen = 0;
    int        err_count    = 0;
    int        stall_cycles = 0;
    int        hold_cnt     = 0;
    bit        hold_arm     = 1'b0;
    bit        hold_used    = 1'b0;

    dash_command_frame_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #HALF_PERIOD aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Frame decoder predictor
    // ------------------------------------------------------------------
    // Digit value at a frame position, with 32-bit wraparound
    function automatic logic [31:0] digit_val(input int pos);
        return {24'd0, frame_q[pos]} - {24'd0, DIGIT_BASE};
    endfunction

    function automatic lamps_t lamp_cmd(input lamps_t lamps, input int bit_idx,
                                        input int pos);
        byte_t cmd;
        cmd = frame_q[pos] - DIGIT_BASE;
        if (cmd == LAMP_CMD_ON)
            lamps[bit_idx] = 1'b1;
        else if (cmd == LAMP_CMD_OFF)
            lamps[bit_idx] = 1'b0;
        return lamps;
    endfunction

    // Returns 1 when the byte completes a frame
    function automatic bit decode_byte(input byte_t b, output result_t upd);
        logic [31:0] rpm;
        logic [31:0] spd;
        upd  = '0;
        if (b == START_CHAR)
            pos_q = '0;
        else if (pos_q == 0)
            return 1'b0;
        if (pos_q < FRAME_LEN)
            frame_q[pos_q[POS_W-1:0]] = b;
        pos_q = pos_q + 1'b1;
        if (b != END_CHAR || pos_q != FRAME_LEN)
            return 1'b0;

        rpm = digit_val(RPM_POS_0) * 1000 + digit_val(RPM_POS_0 + 1) * 100
            + digit_val(RPM_POS_0 + 2) * 10 + digit_val(RPM_POS_0 + 3);
        spd = digit_val(SPEED_POS_0) * 100 + digit_val(SPEED_POS_0 + 1) * 10
            + digit_val(SPEED_POS_0 + 2);
        upd.engine_rpm    = rpm[15:0];
        upd.road_speed    = spd[7:0];
        upd.speed_changed = (spd[7:0] != last_speed_q);
        last_speed_q      = spd[7:0];

        lamps_q = lamp_cmd(lamps_q, LAMP_LEFT, LEFT_POS);
        lamps_q = lamp_cmd(lamps_q, LAMP_RIGHT, RIGHT_POS);
        lamps_q = lamp_cmd(lamps_q, LAMP_BEAM, BEAM_POS);
        upd.left_lamp_on  = lamps_q[LAMP_LEFT];
        upd.right_lamp_on = lamps_q[LAMP_RIGHT];
        upd.beam_lamp_on  = lamps_q[LAMP_BEAM];
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Byte sources
    // ------------------------------------------------------------------
    function automatic byte_t any_but_start();
        byte_t b;
        do b = byte_t'($urandom); while (b == START_CHAR);
        return b;
    endfunction

    function automatic byte_t ascii_digit();
        if ($urandom_range(99) < 85)
            return DIGIT_BASE + byte_t'($urandom_range(9));
        return any_but_start();
    endfunction

    function automatic byte_t separator();
        if ($urandom_range(99) < 80)
            return SPACE_CHAR;
        return any_but_start();
    endfunction

    // Lamp command: mostly on/off, sometimes a no-op digit or junk
    function automatic byte_t lamp_char();
        case ($urandom_range(5))
            0, 1:    return DIGIT_BASE + LAMP_CMD_ON;
            2, 3:    return DIGIT_BASE + LAMP_CMD_OFF;
            4:       return DIGIT_BASE + byte_t'($urandom_range(9));
            default: return any_but_start();
        endcase
    endfunction

    function automatic void add_text(input string s, input bit typed,
                                     input bit ends_upd, input result_t upd);
        stim_row_t row;
        for (int i = 0; i < s.len(); i++) begin
            row.rx      = s[i];
            row.typed   = typed;
            row.has_upd = ends_upd && (i == s.len() - 1);
            row.upd     = upd;
            stim_table.push_back(row);
        end
    endfunction

    // ------------------------------------------------------------------
    // Input channel
    // ------------------------------------------------------------------
    task automatic send_byte(input byte_t b, output bit got, output result_t upd);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        got = decode_byte(b, upd);
        sent_items++;
    endtask

    task automatic expect_update(input result_t upd);
        updates_due_q.push_back(upd);
        updates_seen++;
    endtask

    task automatic offer(input byte_t b);
        bit      got;
        result_t upd;
        send_byte(b, got, upd);
        if (got)
            expect_update(upd);
    endtask

    // Sender pauses until every outstanding update has been taken
    task automatic drain();
        s_tvalid <= 1'b0;
        while (updates_due_q.size() != 0)
            @(posedge aclk);
    endtask

    // One random burst: mostly good frames, the rest broken or noise
    task automatic play_burst();
        byte_t burst [$];
        int    pick;
        int    len;
        pick = $urandom_range(99);
        if (pick < 70) begin
            burst.push_back(START_CHAR);
            repeat (4) burst.push_back(ascii_digit());
            burst.push_back(separator());
            // repeat the previous speed now and then to clear the change flag
            if ($urandom_range(99) >= 30) begin
                foreach (speed_prev[i]) speed_prev[i] = ascii_digit();
            end
            foreach (speed_prev[i]) burst.push_back(speed_prev[i]);
            repeat (3) begin
                burst.push_back(separator());
                burst.push_back(lamp_char());
            end
            burst.push_back(END_CHAR);
        end else if (pick < 80) begin
            // raw noise, any byte at all
            repeat ($urandom_range(1, 20)) burst.push_back(byte_t'($urandom));
        end else if (pick < 88) begin
            // terminator too early
            burst.push_back(START_CHAR);
            repeat ($urandom_range(0, 13)) burst.push_back(ascii_digit());
            burst.push_back(END_CHAR);
        end else if (pick < 95) begin
            // overlong frame
            burst.push_back(START_CHAR);
            len = $urandom_range(15, 40);
            repeat (len) burst.push_back(any_but_start());
            burst.push_back(END_CHAR);
        end else begin
            // abandoned frame, the next start restarts it
            burst.push_back(START_CHAR);
            repeat ($urandom_range(1, 14)) burst.push_back(ascii_digit());
        end
        foreach (burst[i]) offer(burst[i]);
    endtask

    // ------------------------------------------------------------------
    // Output channel: random back-pressure plus one long hold-off
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cnt != 0) begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else if (hold_arm && !hold_used && m_tvalid) begin
            m_tready  <= 1'b0;
            hold_cnt  <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
        if (want !== seen) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
                $display("mismatch on %s: expected 0x%0h, got 0x%0h",
                         name, want, seen);
        end
    endtask

    // Compare each update item taken against the oldest prediction
    always @(posedge aclk) begin : check_updates
        result_t want;
        result_t seen;
        if (aresetn && m_tvalid && m_tready) begin
            seen = result_t'(m_tdata[RESULT_W-1:0]);
            if (updates_due_q.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("unexpected update item: expected none, got 0x%0h",
                             m_tdata);
            end else begin
                want = updates_due_q.pop_front();
                check_field("engine_rpm", 32'(want.engine_rpm),
                            32'(seen.engine_rpm));
                check_field("road_speed", 32'(want.road_speed),
                            32'(seen.road_speed));
                check_field("speed_changed", 32'(want.speed_changed),
                            32'(seen.speed_changed));
                check_field("left_lamp_on", 32'(want.left_lamp_on),
                            32'(seen.left_lamp_on));
                check_field("right_lamp_on", 32'(want.right_lamp_on),
                            32'(seen.right_lamp_on));
                check_field("beam_lamp_on", 32'(want.beam_lamp_on),
                            32'(seen.beam_lamp_on));
                check_field("tdata padding", '0, 32'(m_tdata[31:RESULT_W]));
            end
        end
    end

    // Watchdog on cycles with no item moving on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        result_t first_upd;
        result_t none;
        bit      got;
        result_t upd;

        pos_q        = '0;
        last_speed_q = '0;
        lamps_q      = '0;
        foreach (frame_q[i]) frame_q[i] = '0;
        foreach (speed_prev[i]) speed_prev[i] = DIGIT_BASE;

        // Directed table: stray bytes while idle, a frame of engine speed 9999 and road speed 255
        // with all lamps on, a restart closed at the wrong position, then a zero frame predicted in-bench
        none                    = '0;
        first_upd               = '0;
        first_upd.engine_rpm    = 16'd9999;
        first_upd.road_speed    = 8'd255;
        first_upd.speed_changed = 1'b1;
        first_upd.left_lamp_on  = 1'b1;
        first_upd.right_lamp_on = 1'b1;
        first_upd.beam_lamp_on  = 1'b1;
        add_text("x|", 1'b1, 1'b0, none);
        add_text("$9999 255 1 1 1|", 1'b1, 1'b1, first_upd);
        add_text("$12|", 1'b1, 1'b0, none);
        add_text("$0000 000 2 0 2|", 1'b0, 1'b0, none);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_table[i]) begin
            send_byte(stim_table[i].rx, got, upd);
            if (stim_table[i].typed) begin
                if (stim_table[i].has_upd)
                    expect_update(stim_table[i].upd);
            end else if (got) begin
                expect_update(upd);
            end
        end
        drain();

        // Random phases: sender-light, receiver-light, then free running
        for (int ph = 0; ph < 3; ph++) begin
            int target;
            tx_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 65 : 0;
            rx_idle_pct = (ph == 0) ? 65 : (ph == 1) ? 23 : 0;
            if (ph == 1) begin
                // counter runs through its wrap; trailing bytes are dropped
                offer(START_CHAR);
                repeat (255) offer(any_but_start());
                offer(DIGIT_BASE);
                offer(END_CHAR);
            end
            if (ph == 2)
                hold_arm = 1'b1;
            target = sent_items + ITEMS_PER_RUN;
            while (sent_items < target || (ph == 2 && updates_seen < MIN_UPDATES))
                play_burst();
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (err_count == 0 && updates_due_q.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/dcfd_pkg.sv
rtl/dcfd_decode.sv
rtl/dash_command_frame_decoder.sv
rtl/dcfd_checker.sv
sim/testbench.sv
